@@ rtl/priority_process_queue_macros.svh @@
// Assertion macros used by the verification checker of the process queue.
`ifndef PRIORITY_PROCESS_QUEUE_MACROS_SVH
`define PRIORITY_PROCESS_QUEUE_MACROS_SVH

// Checked at every clock edge except while reset is held.
`define PPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ppq assertion failed");

// Checked at every clock edge, reset included.
`define PPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ppq assertion failed");

`endif

@@ rtl/ppq_pkg.sv @@
package ppq_pkg;

    // Queue geometry and field widths.
    localparam int LEVEL_DEPTH = 8;
    localparam int NUM_LEVELS  = 6;
    localparam int TAG_BITS    = 8;
    localparam int TIME_BITS   = 16;
    localparam int PRIO_BITS   = 3;
    localparam int STATUS_BITS = 3;

    localparam int LVL_W     = $clog2(NUM_LEVELS);
    localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ENTRY_W   = TAG_BITS + TIME_BITS;

    // Request operation codes.
    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_ADDED      = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_FULL       = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_BAD_PRIO   = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
        logic out_busy;
    } t_dp_stat;

endpackage

@@ rtl/ppq_ctrl.sv @@
module ppq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  ppq_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output ppq_pkg::t_cmd     o_cmd
);
    import ppq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The result register can take a new result when empty or being drained.
    assign out_free = !i_stat.out_busy || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_stat.need_read ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ppq_dp.sv @@
module ppq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppq_pkg::t_cmd                 i_cmd,
    input  logic                          i_func,
    input  logic [ppq_pkg::TAG_BITS-1:0]  i_process_tag,
    input  logic [ppq_pkg::TIME_BITS-1:0] i_run_time,
    input  logic [ppq_pkg::PRIO_BITS-1:0] i_priority_level,
    input  logic                          i_out_ready,
    output ppq_pkg::t_dp_stat             o_stat,
    output logic                          o_out_valid,
    output logic [ppq_pkg::STATUS_BITS-1:0] o_status,
    output logic [ppq_pkg::TAG_BITS-1:0]  o_out_tag,
    output logic [ppq_pkg::TIME_BITS-1:0] o_out_run_time,
    output logic [ppq_pkg::PRIO_BITS-1:0] o_out_priority
);
    import ppq_pkg::*;

    // Captured request.
    logic                 r_func;
    logic [TAG_BITS-1:0]  r_tag;
    logic [TIME_BITS-1:0] r_time;
    logic [PRIO_BITS-1:0] r_prio;

    // Per-level FIFO bookkeeping.
    logic [PTR_W-1:0] r_head  [NUM_LEVELS];
    logic [PTR_W-1:0] r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0] r_count [NUM_LEVELS];

    // Entry memory and its registered read port.
    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [LVL_W-1:0]   r_rd_lvl;

    // Result register.
    logic                 r_out_valid;
    t_status              r_status;
    logic [TAG_BITS-1:0]  r_out_tag;
    logic [TIME_BITS-1:0] r_out_time;
    logic [PRIO_BITS-1:0] r_out_prio;

    logic [LVL_W-1:0]  add_lvl;
    logic [LVL_W-1:0]  disp_lvl;
    logic              prio_ok;
    logic              lvl_full;
    logic              found;
    logic              add_ok;
    logic              need_read;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    t_status           exec_status;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_tag  <= i_process_tag;
            r_time <= i_run_time;
            r_prio <= i_priority_level;
        end
    end

    // Decode of the captured request against the level state.
    always_comb begin
        add_lvl  = LVL_W'(r_prio);
        prio_ok  = 32'(r_prio) < NUM_LEVELS;
        lvl_full = prio_ok && (r_count[add_lvl] == CNT_W'(LEVEL_DEPTH));
        found    = 1'b0;
        disp_lvl = '0;
        // Lowest-numbered non-empty level wins.
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                found    = 1'b1;
                disp_lvl = LVL_W'(l);
            end
        end
        add_ok    = (r_func == FUNC_ADD) && prio_ok && !lvl_full;
        need_read = (r_func == FUNC_DISPATCH) && found;
        wr_addr   = ADDR_W'(ADDR_W'(add_lvl) * ADDR_W'(LEVEL_DEPTH))
                    + ADDR_W'(r_tail[add_lvl]);
        rd_addr   = ADDR_W'(ADDR_W'(disp_lvl) * ADDR_W'(LEVEL_DEPTH))
                    + ADDR_W'(r_head[disp_lvl]);
        if (r_func == FUNC_DISPATCH) begin
            exec_status = ST_EMPTY;
        end else if (!prio_ok) begin
            exec_status = ST_BAD_PRIO;
        end else if (lvl_full) begin
            exec_status = ST_FULL;
        end else begin
            exec_status = ST_ADDED;
        end
    end

    assign o_stat.need_read = need_read;
    assign o_stat.out_busy  = r_out_valid;

    // Head, tail and fill count of each level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (add_ok) begin
                r_tail[add_lvl]  <= (r_tail[add_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
                                    '0 : r_tail[add_lvl] + 1'b1;
                r_count[add_lvl] <= r_count[add_lvl] + 1'b1;
            end else if (need_read) begin
                r_head[disp_lvl]  <= (r_head[disp_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
                                     '0 : r_head[disp_lvl] + 1'b1;
                r_count[disp_lvl] <= r_count[disp_lvl] - 1'b1;
            end
        end
    end

    // Entry memory: one write or one read per request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && add_ok) begin
            r_mem[wr_addr] <= {r_tag, r_time};
        end
        if (i_cmd.exec && need_read) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_lvl  <= disp_lvl;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && !need_read) || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !need_read) begin
            r_status   <= exec_status;
            r_out_tag  <= '0;
            r_out_time <= '0;
            r_out_prio <= '0;
        end else if (i_cmd.finish) begin
            r_status   <= ST_DISPATCHED;
            r_out_tag  <= r_rd_data[ENTRY_W-1:TIME_BITS];
            r_out_time <= r_rd_data[TIME_BITS-1:0];
            r_out_prio <= PRIO_BITS'(r_rd_lvl);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_tag      = r_out_tag;
    assign o_out_run_time = r_out_time;
    assign o_out_priority = r_out_prio;

endmodule

@@ rtl/priority_process_queue.sv @@
// Channel   Handshake                     Payload
// request   i_in_valid / o_in_ready       i_func, i_process_tag, i_run_time,
//                                         i_priority_level
// result    o_out_valid / i_out_ready     o_status, o_out_tag, o_out_run_time,
//                                         o_out_priority
//
// The accepting edge captures a request; the execute state decides it and touches the
// entry memory; a dispatch then passes the read state for the registered memory read.
// A new request is taken only once the previous one has left the execute state (add)
// or the read state (dispatch); both states wait for the result register to free.
// Synchronous active-low reset empties every level; the entry memory is not cleared.
// A waiting result does not block acceptance; the next request stalls before any
// state change until the result register frees.
module priority_process_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [ppq_pkg::TAG_BITS-1:0]  i_process_tag,
    input  logic [ppq_pkg::TIME_BITS-1:0] i_run_time,
    input  logic [ppq_pkg::PRIO_BITS-1:0] i_priority_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ppq_pkg::STATUS_BITS-1:0] o_status,
    output logic [ppq_pkg::TAG_BITS-1:0]  o_out_tag,
    output logic [ppq_pkg::TIME_BITS-1:0] o_out_run_time,
    output logic [ppq_pkg::PRIO_BITS-1:0] o_out_priority
);
    import ppq_pkg::*;

    t_cmd     cmd;
    t_dp_stat dp_stat;

    // Sequencing of each request.
    ppq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // Level FIFOs, entry memory and result register.
    ppq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_func),
        .i_process_tag    (i_process_tag),
        .i_run_time       (i_run_time),
        .i_priority_level (i_priority_level),
        .i_out_ready      (i_out_ready),
        .o_stat           (dp_stat),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_out_tag        (o_out_tag),
        .o_out_run_time   (o_out_run_time),
        .o_out_priority   (o_out_priority)
    );

endmodule

@@ rtl/ppq_checker.sv @@
`include "priority_process_queue_macros.svh"

module ppq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ppq_pkg::STATUS_BITS-1:0] i_status,
    input logic [ppq_pkg::TAG_BITS-1:0]  i_out_tag,
    input logic [ppq_pkg::TIME_BITS-1:0] i_out_run_time,
    input logic [ppq_pkg::PRIO_BITS-1:0] i_out_priority
);
    import ppq_pkg::*;

    // Reset leaves no result pending.
    `PPQ_ASSERT_ALWAYS(a_reset_clears_result, i_clk, !i_rst_n |=> !i_out_valid)

    // A stalled result keeps its payload.
    `PPQ_ASSERT(a_result_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_tag) && $stable(i_out_run_time) && $stable(i_out_priority))

    // Only a dispatch carries process fields.
    `PPQ_ASSERT(a_zero_fields, i_clk, i_rst_n,
        i_out_valid && (i_status != ST_DISPATCHED) |-> (i_out_tag == '0)
            && (i_out_run_time == '0) && (i_out_priority == '0))

    // One request is worked on at a time.
    `PPQ_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

endmodule

bind priority_process_queue ppq_checker u_ppq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_ready     (o_in_ready),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_status       (o_status),
    .i_out_tag      (o_out_tag),
    .i_out_run_time (o_out_run_time),
    .i_out_priority (o_out_priority)
);
